@@ rtl/pwsft_pkg.sv @@
// ----------------------------------------------------------------------------
// pwsft_pkg
// Shared widths, register indexes, result type and the CRC-8 helpers of the
// pulse-width sensor frame transmitter.
// ----------------------------------------------------------------------------
package pwsft_pkg;

    // Frame layout: preamble, id, temperature, humidity, crc
    localparam int FRAME_W   = 48;
    localparam int FIDX_W    = 6;
    localparam int PAYLOAD_W = 32;
    localparam int CRC_BYTES = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_BYTE = 3'd7;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic start_refused;
        logic busy_res;
        logic tx_power;
        logic tx_line;
    } result_t;

    // One byte of an MSB-first CRC-8: eight shift-and-reduce steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] rem_in,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] rem;
        rem = rem_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (rem[7]) begin
                rem = {rem[6:0], 1'b0} ^ poly;
            end else begin
                rem = {rem[6:0], 1'b0};
            end
        end
        return rem;
    endfunction

    // Whole payload, most significant byte first; flattens to an XOR network
    function automatic logic [7:0] crc8_payload(input logic [7:0]           init,
                                                input logic [PAYLOAD_W-1:0] payload,
                                                input logic [7:0]           poly);
        logic [7:0] rem;
        rem = init;
        for (int b = 0; b < CRC_BYTES; b++) begin
            rem = crc8_byte(rem, payload[PAYLOAD_W-1-8*b -: 8], poly);
        end
        return rem;
    endfunction

endpackage

@@ rtl/pulse_width_sensor_frame_transmitter_top.sv @@
// ----------------------------------------------------------------------------
// pulse_width_sensor_frame_transmitter_top
// On-off-keyed pulse-width frame transmitter with a CRC-8 over the payload.
// ----------------------------------------------------------------------------
// Every request on the input stream gives exactly one result. A tick advances
// the line one time step; a start while idle loads a new frame and opens a
// burst of repeat_count copies, and a start during a burst is refused. The CRC
// over the four payload bytes is formed in the same cycle as the start is
// accepted, and each result is in the output register in the next cycle. One
// request is taken per clock cycle; the input stalls only while a result waits
// in the output register and the sink holds m_tready low. Configuration must be
// written via cfg_we/cfg_index/cfg_data while no burst runs; it is not enforced.
module pulse_width_sensor_frame_transmitter_top #(
    parameter int FRAME_BITS = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // device_id[11:0], temperature[23:12], humidity[31:24]
    input  logic [pwsft_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode[0]: 0 tick, 1 start
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tx_line[0], tx_power[1], busy_res[2], start_refused[3], zero[7:4]
    output logic [pwsft_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [pwsft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwsft_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pwsft_pkg::*;

    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam logic [IDX_W-1:0] START_IDX = IDX_W'(FRAME_BITS - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_GAP  = 2'd3;

    // Configuration registers
    logic [7:0] low_ticks_reg, zero_high_reg, one_high_reg, gap_ticks_reg;
    logic [3:0] repeat_count_reg;
    logic [7:0] crc_poly_reg, crc_init_reg, preamble_reg;

    // Burst state
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [IDX_W-1:0]     bit_index_reg, bit_index_next;
    logic [1:0]           phase_reg, phase_next;
    logic [7:0]           tick_count_reg, tick_count_next;
    logic [3:0]           copies_left_reg, copies_left_next;

    // Output register
    logic                 m_valid_reg;
    result_t              m_data_reg;
    result_t              result;

    logic                 in_accept;
    logic [PAYLOAD_W-1:0] payload;
    logic [7:0]           crc_val;
    logic [FIDX_W-1:0]    idx_ext;
    logic                 cur_bit;
    logic [7:0]           tick_inc;
    logic [7:0]           high_dur;
    logic [3:0]           copies_dec;
    logic                 busy;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - $bits(result_t)){1'b0}}, m_data_reg};

    // Big-endian payload: id, temperature, humidity
    assign payload  = {s_tdata[11:0], s_tdata[23:12], s_tdata[31:24]};
    assign crc_val  = crc8_payload(crc_init_reg, payload, crc_poly_reg);
    assign idx_ext  = FIDX_W'(bit_index_reg);
    assign cur_bit  = (idx_ext < FIDX_W'(FRAME_W)) ? frame_reg[idx_ext] : 1'b0;
    assign tick_inc = tick_count_reg + 8'd1;
    assign high_dur = cur_bit ? one_high_reg : zero_high_reg;
    assign copies_dec = copies_left_reg - 4'd1;

    always_comb begin
        frame_next       = frame_reg;
        bit_index_next   = bit_index_reg;
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        copies_left_next = copies_left_reg;
        busy             = (phase_reg != PH_IDLE);
        result.tx_line       = (phase_reg == PH_HIGH);
        result.start_refused = 1'b0;

        if (in_accept) begin
            if (s_tuser) begin
                if (busy) begin
                    result.start_refused = 1'b1;
                end else begin
                    frame_next       = {preamble_reg, payload, crc_val};
                    bit_index_next   = START_IDX;
                    phase_next       = PH_LOW;
                    tick_count_next  = 8'd0;
                    copies_left_next = (repeat_count_reg == 4'd0) ? 4'd1
                                                                  : repeat_count_reg;
                    busy             = 1'b1;
                    result.tx_line   = 1'b0;
                end
            end else if (busy) begin
                tick_count_next = tick_inc;
                unique case (phase_reg)
                    PH_LOW: begin
                        if (tick_inc >= low_ticks_reg) begin
                            phase_next      = PH_HIGH;
                            tick_count_next = 8'd0;
                        end
                    end
                    PH_HIGH: begin
                        if (tick_inc >= high_dur) begin
                            tick_count_next = 8'd0;
                            if (bit_index_reg == '0) begin
                                if (gap_ticks_reg == 8'd0) begin
                                    copies_left_next = copies_dec;
                                    if (copies_dec == 4'd0) begin
                                        phase_next     = PH_IDLE;
                                        bit_index_next = '0;
                                    end else begin
                                        phase_next     = PH_LOW;
                                        bit_index_next = START_IDX;
                                    end
                                end else begin
                                    phase_next = PH_GAP;
                                end
                            end else begin
                                bit_index_next = bit_index_reg - IDX_W'(1);
                                phase_next     = PH_LOW;
                            end
                        end
                    end
                    PH_GAP: begin
                        if (tick_inc >= gap_ticks_reg) begin
                            tick_count_next  = 8'd0;
                            copies_left_next = copies_dec;
                            if (copies_dec == 4'd0) begin
                                phase_next     = PH_IDLE;
                                bit_index_next = '0;
                            end else begin
                                phase_next     = PH_LOW;
                                bit_index_next = START_IDX;
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        result.tx_power = busy;
        result.busy_res = busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_ticks_reg    <= 8'd2;
            zero_high_reg    <= 8'd3;
            one_high_reg     <= 8'd1;
            gap_ticks_reg    <= 8'd1;
            repeat_count_reg <= 4'd4;
            crc_poly_reg     <= 8'h31;
            crc_init_reg     <= 8'h00;
            preamble_reg     <= 8'hFF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LOW_TICKS:     low_ticks_reg    <= cfg_data;
                REG_ZERO_HIGH:     zero_high_reg    <= cfg_data;
                REG_ONE_HIGH:      one_high_reg     <= cfg_data;
                REG_GAP_TICKS:     gap_ticks_reg    <= cfg_data;
                REG_REPEAT_COUNT:  repeat_count_reg <= cfg_data[3:0];
                REG_CRC_POLY:      crc_poly_reg     <= cfg_data;
                REG_CRC_INIT:      crc_init_reg     <= cfg_data;
                REG_PREAMBLE_BYTE: preamble_reg     <= cfg_data;
                default:           preamble_reg     <= preamble_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg       <= '0;
            bit_index_reg   <= '0;
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= 8'd0;
            copies_left_reg <= 4'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            frame_reg       <= frame_next;
            bit_index_reg   <= bit_index_next;
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            copies_left_reg <= copies_left_next;
            if (in_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= result;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_idle_no_copies: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (copies_left_reg == 4'd0))
        else $error("idle with frame copies left");

    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser && phase_reg == PH_IDLE)
        |=> (phase_reg == PH_LOW && bit_index_reg == START_IDX))
        else $error("start did not open a burst");

    a_refused_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.start_refused) |-> m_data_reg.busy_res)
        else $error("refused start reported while idle");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        FIDX_W'(bit_index_reg) <= FIDX_W'(FRAME_BITS - 1))
        else $error("bit index beyond frame length");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result changed or dropped");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-width sensor frame transmitter. Start and
// tick requests go in on the input stream. A cycle-free model of the line
// sequencer predicts the level, power, busy and refusal flags of every
// request, and each returned result is compared in order. Directed bursts
// cover reset timing, zero durations, wide repeat values and repeated copies.
// Random bursts follow, with refused starts, random stalls on both streams
// and register changes while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pwsft_pkg::*;

    localparam int   FRAME_LEN   = 48;
    localparam int   STALL_LIMIT = 2000;
    localparam int   TOTAL_ITEMS = 1200;
    localparam int   TAIL_ITEMS  = 200;
    localparam int   SETTLE      = 8;
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_START  = 1'b1;

    typedef enum logic [1:0] {PH_IDLE, PH_LOW, PH_HIGH, PH_GAP} tx_phase_e;

    class ook_burst_checker;
        logic [7:0]  low_ticks, zero_high, one_high, gap_ticks;
        logic [3:0]  repeat_count;
        logic [7:0]  crc_poly, crc_init, preamble;
        logic [63:0] frame;
        logic [5:0]  bit_idx;
        tx_phase_e   phase;
        logic [7:0]  tick_cnt;
        logic [3:0]  copies_left;
        result_t     pending_levels[$];
        int          errors;

        function new();
            low_ticks    = 8'd2;
            zero_high    = 8'd3;
            one_high     = 8'd1;
            gap_ticks    = 8'd1;
            repeat_count = 4'd4;
            crc_poly     = 8'h31;
            crc_init     = 8'h00;
            preamble     = 8'hFF;
            frame        = '0;
            bit_idx      = '0;
            phase        = PH_IDLE;
            tick_cnt     = '0;
            copies_left  = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LOW_TICKS:     low_ticks    = val;
                REG_ZERO_HIGH:     zero_high    = val;
                REG_ONE_HIGH:      one_high     = val;
                REG_GAP_TICKS:     gap_ticks    = val;
                REG_REPEAT_COUNT:  repeat_count = val[3:0];
                REG_CRC_POLY:      crc_poly     = val;
                REG_CRC_INIT:      crc_init     = val;
                REG_PREAMBLE_BYTE: preamble     = val;
                default: ;
            endcase
        endfunction

        // MSB-first CRC-8 over the four payload bytes
        function logic [7:0] payload_crc(logic [31:0] payload);
            logic [7:0] rem;
            rem = crc_init;
            for (int b = 0; b < 4; b++) begin
                rem = rem ^ payload[31 - 8 * b -: 8];
                for (int k = 0; k < 8; k++) begin
                    rem = rem[7] ? ({rem[6:0], 1'b0} ^ crc_poly) : {rem[6:0], 1'b0};
                end
            end
            return rem;
        endfunction

        function void close_copy();
            copies_left = copies_left - 4'd1;
            tick_cnt    = '0;
            if (copies_left == 4'd0) begin
                phase   = PH_IDLE;
                bit_idx = '0;
            end else begin
                phase   = PH_LOW;
                bit_idx = 6'(FRAME_LEN - 1);
            end
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        function void take_request(logic mode, logic [31:0] data);
            logic [31:0] payload;
            logic [7:0]  dur;
            logic        active, line, refused;
            result_t     lv;
            active  = (phase != PH_IDLE);
            line    = (phase == PH_HIGH);
            refused = 1'b0;
            if (mode == MODE_START) begin
                if (active) begin
                    refused = 1'b1;
                end else begin
                    payload     = {data[11:0], data[23:12], data[31:24]};
                    frame       = {16'h0, preamble, payload, payload_crc(payload)};
                    bit_idx     = 6'(FRAME_LEN - 1);
                    phase       = PH_LOW;
                    tick_cnt    = '0;
                    copies_left = (repeat_count == 4'd0) ? 4'd1 : repeat_count;
                    active      = 1'b1;
                    line        = 1'b0;
                end
            end else if (active) begin
                tick_cnt = tick_cnt + 8'd1;
                case (phase)
                    PH_LOW: begin
                        if (tick_cnt >= low_ticks) begin
                            phase    = PH_HIGH;
                            tick_cnt = '0;
                        end
                    end
                    PH_HIGH: begin
                        dur = frame[bit_idx] ? one_high : zero_high;
                        if (tick_cnt >= dur) begin
                            tick_cnt = '0;
                            if (bit_idx == 6'd0) begin
                                if (gap_ticks == 8'd0) begin
                                    close_copy();
                                end else begin
                                    phase = PH_GAP;
                                end
                            end else begin
                                bit_idx = bit_idx - 6'd1;
                                phase   = PH_LOW;
                            end
                        end
                    end
                    default: begin
                        if (tick_cnt >= gap_ticks) close_copy();
                    end
                endcase
            end
            lv.tx_line       = line;
            lv.tx_power      = active;
            lv.busy_res      = active;
            lv.start_refused = refused;
            pending_levels.push_back(lv);
        endfunction

        function void compare_field(string name, logic [3:0] exp_v, logic [3:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_levels(logic [M_TDATA_W-1:0] tdata);
            result_t lv;
            if (pending_levels.size() == 0) begin
                $error("result 0x%02h arrived with no request outstanding", tdata);
                errors++;
                return;
            end
            lv = pending_levels.pop_front();
            compare_field("tx_line", 4'(lv.tx_line), 4'(tdata[0]));
            compare_field("tx_power", 4'(lv.tx_power), 4'(tdata[1]));
            compare_field("busy_res", 4'(lv.busy_res), 4'(tdata[2]));
            compare_field("start_refused", 4'(lv.start_refused), 4'(tdata[3]));
            compare_field("reserved", 4'h0, tdata[7:4]);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ook_burst_checker sb;
    bit idling = 1'b1;
    int stall_left = 0;
    int sent_count = 0;
    int quiet_cycles = 0;
    int item_cap = 32'h7FFF_FFFF;

    pulse_width_sensor_frame_transmitter_top #(
        .FRAME_BITS(FRAME_LEN)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_levels(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pack_fields(logic [11:0] id, logic [11:0] temp,
                                                logic [7:0] hum);
        return {hum, temp, id};
    endfunction

    task automatic send_request(input logic mode, input logic [31:0] data);
        int gap;
        // No idling in the last part of the run
        if (sent_count >= TOTAL_ITEMS - TAIL_ITEMS) idling = 1'b0;
        if (idling && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_request(mode, data);
        sent_count++;
    endtask

    // Drop valid and hold until every result is back
    task automatic wait_drained(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [7:0] lo, input logic [7:0] zh,
                                  input logic [7:0] oh, input logic [7:0] gp,
                                  input logic [7:0] rc, input logic [7:0] poly,
                                  input logic [7:0] init, input logic [7:0] pre);
        wait_drained(SETTLE);
        cfg_write(REG_LOW_TICKS, lo);
        cfg_write(REG_ZERO_HIGH, zh);
        cfg_write(REG_ONE_HIGH, oh);
        cfg_write(REG_GAP_TICKS, gp);
        cfg_write(REG_REPEAT_COUNT, rc);
        cfg_write(REG_CRC_POLY, poly);
        cfg_write(REG_CRC_INIT, init);
        cfg_write(REG_PREAMBLE_BYTE, pre);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_settings();
        logic [7:0] lo, zh, oh, gp, rc;
        lo = 8'($urandom_range(0, 2));
        zh = 8'($urandom_range(0, 2));
        oh = 8'($urandom_range(0, 2));
        gp = 8'($urandom_range(0, 8));
        // upper nibble is junk the register must drop
        rc = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 2))};
        apply_settings(lo, zh, oh, gp, rc, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    endtask

    // Tick until the burst ends; refuse_pct of the requests are extra starts
    task automatic finish_burst(input int refuse_pct);
        while (sb.busy() && sent_count < item_cap) begin
            if ($urandom_range(0, 299) == 0) wait_drained(SETTLE);
            if ($urandom_range(0, 99) < refuse_pct) begin
                send_request(MODE_START, $urandom());
            end else begin
                send_request(MODE_TICK, $urandom());
            end
        end
    endtask

    initial begin
        int bursts;
        sb = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset timing with one copy: idle tick, start with zero fields,
        // refused start with all ones
        cfg_write(REG_REPEAT_COUNT, 8'd1);
        @(negedge aclk);
        cfg_we <= 1'b0;
        send_request(MODE_TICK, '1);
        send_request(MODE_START, pack_fields(12'h000, 12'h000, 8'h00));
        repeat (5) send_request(MODE_TICK, $urandom());
        send_request(MODE_START, '1);
        finish_burst(0);

        // Shortest timing, one copy, no gap
        apply_settings(8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'h00, 8'hFF, 8'h00);
        send_request(MODE_START, pack_fields(12'hFFF, 12'hFFF, 8'hFF));
        finish_burst(0);

        // Zero durations and zero repeat act as one; back-to-back starts
        apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 8'h00, 8'hAA);
        send_request(MODE_START, pack_fields(12'hA5A, 12'h5A5, 8'h3C));
        finish_burst(0);
        send_request(MODE_START, pack_fields(12'h5A5, 12'hA5A, 8'hC3));
        finish_burst(2);

        // Wide repeat value truncates to one, gap after the frame
        apply_settings(8'd1, 8'd2, 8'd1, 8'd3, 8'hF1, 8'h07, 8'h55, 8'hFF);
        send_request(MODE_START, $urandom());
        finish_burst(0);

        // Two copies with a gap between them
        apply_settings(8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'h31, 8'h00, 8'hFF);
        send_request(MODE_START, $urandom());
        finish_burst(1);

        bursts   = 0;
        item_cap = TOTAL_ITEMS;
        while (sent_count < TOTAL_ITEMS) begin
            if (bursts % 2 == 0) random_settings();
            idling = (sent_count < TOTAL_ITEMS - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 3)) send_request(MODE_TICK, $urandom());
            send_request(MODE_START, $urandom());
            finish_burst($urandom_range(0, 5));
            bursts++;
        end

        idling = 1'b0;
        wait_drained(20);
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pwsft_pkg.sv
rtl/pulse_width_sensor_frame_transmitter_top.sv
sim/tb_top.sv
